// ===== rtl/b64c_pkg.sv =====
// Package for the base64 stream codec: payload structs, alphabet constants
// and the character mapping functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package b64c_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_UPPER = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWER = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_DIGIT = 8'h30;  // '0'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [5:0] VAL_LOWER  = 6'd26;
  localparam logic [5:0] VAL_DIGIT  = 6'd52;
  localparam logic [5:0] VAL_PLUS   = 6'd62;
  localparam logic [5:0] VAL_SLASH  = 6'd63;

  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  // Maps a 6-bit value to its alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < VAL_LOWER) begin
      c = CHAR_UPPER + {2'b00, v};
    end else if (v < VAL_DIGIT) begin
      c = CHAR_LOWER + {2'b00, v - VAL_LOWER};
    end else if (v < VAL_PLUS) begin
      c = CHAR_DIGIT + {2'b00, v - VAL_DIGIT};
    end else if (v == VAL_PLUS) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  // Returns {hit, value}; hit is low for characters outside the alphabet.
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [6:0] r;
    if (c >= CHAR_UPPER && c <= 8'h5A) begin
      r = {1'b1, 6'(c - CHAR_UPPER)};
    end else if (c >= CHAR_LOWER && c <= 8'h7A) begin
      r = {1'b1, 6'(c - CHAR_LOWER) + VAL_LOWER};
    end else if (c >= CHAR_DIGIT && c <= 8'h39) begin
      r = {1'b1, 6'(c - CHAR_DIGIT) + VAL_DIGIT};
    end else if (c == CHAR_PLUS) begin
      r = {1'b1, VAL_PLUS};
    end else if (c == CHAR_SLASH) begin
      r = {1'b1, VAL_SLASH};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/base64_stream_codec.sv =====
// Top level of the streaming base64 codec: input register, single-pass
// group computation, result group register and output register.
// Depends on b64c_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Streaming base64 codec. cfg_wdata selects decode (0) or encode (1); a write
// also starts a new message. Each transaction on the input channel is
// computed from the input register into a group of up to four results,
// which leave through the output register at one result per cycle while
// out_stall is low, limited by the single result port. The next item is
// taken into the group register as the last result of the previous group
// moves to the output register. An item's results pass through the input
// register, the group register and the output register. A last item that
// yields no data produces one terminator result with out_valid low.
module base64_stream_codec (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire b64c_pkg::in_item_t in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output b64c_pkg::out_item_t  out_data
);

  logic                dir_r;
  logic [5:0]          held_bits_r, held_bits_nxt;
  logic [2:0]          held_cnt_r, held_cnt_nxt;

  logic                in_v_r;
  b64c_pkg::in_item_t  in_item_r;

  logic                grp_v_r;
  b64c_pkg::out_item_t grp_data_r [4];
  logic [1:0]          grp_last_r;
  logic [1:0]          grp_idx_r;

  logic                out_v_r;
  b64c_pkg::out_item_t out_item_r;

  b64c_pkg::out_item_t res [4];
  logic [2:0]          res_n;

  logic out_take, grp_pop, grp_pop_final, grp_load, in_take;

  assign out_take      = out_v_r && !out_stall;
  assign grp_pop       = grp_v_r && (!out_v_r || out_take);
  assign grp_pop_final = grp_pop && (grp_idx_r == grp_last_r);
  assign grp_load      = in_v_r && (!grp_v_r || grp_pop_final);
  assign in_stall      = in_v_r && !grp_load;
  assign in_take       = in_valid && !in_stall;

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

  // Single-pass computation of all results of the registered item.
  always_comb begin
    logic [6:0]  dec;
    logic [11:0] acc_d;
    logic [3:0]  cnt_d;
    logic [2:0]  cnt_e;
    logic [13:0] acc_e;
    logic [2:0]  c1;
    logic        two;
    logic [2:0]  rem;
    logic [5:0]  held_e;
    logic [5:0]  pad_v;
    logic [2:0]  pads;
    b64c_pkg::out_item_t item;

    for (int i = 0; i < 4; i++) begin
      res[i] = '0;
    end
    res_n         = 3'd0;
    held_bits_nxt = held_bits_r;
    held_cnt_nxt  = held_cnt_r;
    dec    = '0;
    acc_d  = '0;
    cnt_d  = '0;
    cnt_e  = '0;
    acc_e  = '0;
    c1     = '0;
    two    = 1'b0;
    rem    = '0;
    held_e = '0;
    pad_v  = '0;
    pads   = '0;
    item   = '0;

    if (dir_r == b64c_pkg::DIR_DECODE) begin
      dec = b64c_pkg::dec_char(in_item_r.in_byte);
      if (dec[6] && held_cnt_r <= 3'd6) begin
        acc_d = {held_bits_r, dec[5:0]};
        cnt_d = {1'b0, held_cnt_r} + 4'd6;
        if (cnt_d >= 4'd8) begin
          cnt_d = cnt_d - 4'd8;
          item.out_byte  = 8'(acc_d >> cnt_d);
          item.out_valid = 1'b1;
          res[0] = item;
          res_n  = 3'd1;
        end
        held_bits_nxt = 6'(acc_d & ((12'd1 << cnt_d) - 12'd1));
        held_cnt_nxt  = 3'(cnt_d);
      end
    end else begin
      cnt_e = (held_cnt_r > 3'd4) ? 3'd4 : held_cnt_r;
      acc_e = {held_bits_r, in_item_r.in_byte};
      // Holding c bits plus 8 new ones gives one character, or two when c is 4
      // or more; what remains is c + 2 or zero.
      c1  = cnt_e + 3'd2;
      two = (c1 >= 3'd6);
      rem = two ? 3'd0 : c1;
      item.out_valid = 1'b1;
      item.out_byte  = b64c_pkg::enc_char(6'(acc_e >> (c1 + 3'd0)));
      res[0] = item;
      res_n  = 3'd1;
      if (two) begin
        item.out_byte = b64c_pkg::enc_char(acc_e[5:0]);
        res[1] = item;
        res_n  = 3'd2;
      end
      held_e        = 6'(acc_e & ((14'd1 << rem) - 14'd1));
      held_bits_nxt = held_e;
      held_cnt_nxt  = rem;
      if (in_item_r.in_last && rem != 3'd0) begin
        pad_v = 6'(held_e << (3'd6 - rem));
        pads  = (3'd6 - rem) >> 1;
        item.out_byte = b64c_pkg::enc_char(pad_v);
        res[res_n[1:0]] = item;
        res_n = res_n + 3'd1;
        item.out_byte = b64c_pkg::CHAR_PAD;
        if (pads >= 3'd1) begin
          res[res_n[1:0]] = item;
          res_n = res_n + 3'd1;
        end
        if (pads >= 3'd2) begin
          res[res_n[1:0]] = item;
          res_n = res_n + 3'd1;
        end
      end
    end

    if (in_item_r.in_last) begin
      if (res_n == 3'd0) begin
        res[0] = '0;
        res_n  = 3'd1;
      end
      for (int i = 0; i < 4; i++) begin
        res[i].out_last = (3'(i) == res_n - 3'd1);
      end
      held_bits_nxt = '0;
      held_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= b64c_pkg::DIR_DECODE;
      held_bits_r <= '0;
      held_cnt_r  <= '0;
      in_v_r      <= 1'b0;
      grp_v_r     <= 1'b0;
      grp_idx_r   <= '0;
      grp_last_r  <= '0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        dir_r       <= cfg_wdata;
        held_bits_r <= '0;
        held_cnt_r  <= '0;
      end else if (grp_load) begin
        held_bits_r <= held_bits_nxt;
        held_cnt_r  <= held_cnt_nxt;
      end

      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (grp_load) begin
        in_v_r <= 1'b0;
      end

      if (grp_load) begin
        grp_v_r    <= (res_n != 3'd0);
        grp_idx_r  <= '0;
        grp_last_r <= 2'(res_n - 3'd1);
      end else if (grp_pop_final) begin
        grp_v_r <= 1'b0;
      end else if (grp_pop) begin
        grp_idx_r <= grp_idx_r + 2'd1;
      end

      if (grp_pop) begin
        out_v_r <= 1'b1;
      end else if (out_take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (grp_load) begin
      for (int i = 0; i < 4; i++) begin
        grp_data_r[i] <= res[i];
      end
    end
    if (grp_pop) begin
      out_item_r <= grp_data_r[grp_idx_r];
    end
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for base64_stream_codec: drives both directions of
// the codec and checks every result against an in-bench model of the codec.
// Depends on b64c_pkg and the codec RTL.
`timescale 1ns / 1ps

module testbench;
  import b64c_pkg::*;

  localparam int IDLE_PCT     = 29;
  localparam int HOLD_CYCLES  = 90;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 85;
  localparam int MIN_PHASES   = 3;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Tracks the codec's bit holder and keeps the results still owed by it.
  class codec_scoreboard;
    logic       direction;
    bit   [5:0] held_bits;
    bit   [2:0] held_count;
    out_item_t  pending[$];
    out_item_t  group[4];
    int         group_len;
    int         errors;
    int         inputs_seen;
    int         results_seen;
    int         terminators;

    function new();
      direction    = DIR_DECODE;
      held_bits    = '0;
      held_count   = '0;
      errors       = 0;
      inputs_seen  = 0;
      results_seen = 0;
      terminators  = 0;
    endfunction

    // A direction write always starts a new message.
    function void set_direction(logic d);
      direction  = d;
      held_bits  = '0;
      held_count = '0;
    endfunction

    function logic [7:0] sym_of(logic [5:0] v);
      if (v == VAL_SLASH) return CHAR_SLASH;
      if (v == VAL_PLUS) return CHAR_PLUS;
      if (v >= VAL_DIGIT) return CHAR_DIGIT + 8'(v - VAL_DIGIT);
      if (v >= VAL_LOWER) return CHAR_LOWER + 8'(v - VAL_LOWER);
      return CHAR_UPPER + 8'(v);
    endfunction

    // Returns the 6-bit value of a character, or -1 outside the alphabet.
    function int val_of(logic [7:0] c);
      int d;
      if (c == CHAR_PLUS) return int'(VAL_PLUS);
      if (c == CHAR_SLASH) return int'(VAL_SLASH);
      d = int'(c) - int'(CHAR_DIGIT);
      if (d >= 0 && d < int'(VAL_PLUS) - int'(VAL_DIGIT)) return d + int'(VAL_DIGIT);
      d = int'(c) - int'(CHAR_LOWER);
      if (d >= 0 && d < int'(VAL_LOWER)) return d + int'(VAL_LOWER);
      d = int'(c) - int'(CHAR_UPPER);
      if (d >= 0 && d < int'(VAL_LOWER)) return d;
      return -1;
    endfunction

    function void add_result(logic [7:0] b, logic v);
      group[group_len].out_byte  = b;
      group[group_len].out_valid = v;
      group[group_len].out_last  = 1'b0;
      group_len++;
    endfunction

    function void note_item(in_item_t it);
      int acc;
      int cnt;
      int v;
      int pads;
      inputs_seen++;
      group_len = 0;
      cnt = int'(held_count);
      if (direction == DIR_DECODE) begin
        v = val_of(it.in_byte);
        if (v >= 0) begin
          acc = (int'(held_bits) << 6) | v;
          cnt = cnt + 6;
          if (cnt >= 8) begin
            cnt = cnt - 8;
            add_result(8'(acc >> cnt), 1'b1);
          end
          held_bits  = 6'(acc & ((1 << cnt) - 1));
          held_count = 3'(cnt);
        end
      end else begin
        acc = (int'(held_bits) << 8) | int'(it.in_byte);
        cnt = cnt + 8;
        while (cnt >= 6) begin
          cnt = cnt - 6;
          add_result(sym_of(6'(acc >> cnt)), 1'b1);
        end
        held_bits  = 6'(acc & ((1 << cnt) - 1));
        held_count = 3'(cnt);
        // A short final group is closed with zero fill and '=' padding.
        if (it.in_last && cnt > 0) begin
          add_result(sym_of(6'(int'(held_bits) << (6 - cnt))), 1'b1);
          for (pads = (6 - cnt) / 2; pads > 0; pads--) begin
            add_result(CHAR_PAD, 1'b1);
          end
        end
      end
      if (it.in_last) begin
        if (group_len == 0) begin
          add_result(8'h00, 1'b0);
        end
        group[group_len - 1].out_last = 1'b1;
        held_bits  = '0;
        held_count = '0;
      end
      for (int i = 0; i < group_len; i++) begin
        pending = {pending, group[i]};
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (!got.out_valid) begin
        terminators++;
      end
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte expected %h, actual %h", $time, want.out_byte, got.out_byte);
      end
      if (got.out_valid !== want.out_valid) begin
        errors++;
        $display("%0t: out_valid expected %b, actual %b", $time, want.out_valid,
                 got.out_valid);
      end
      if (got.out_last !== want.out_last) begin
        errors++;
        $display("%0t: out_last expected %b, actual %b", $time, want.out_last,
                 got.out_last);
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic      cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  codec_scoreboard sb;
  bit no_idle;
  bit hold_req;
  int random_items;
  int dir_writes;

  base64_stream_codec i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #500000;
    $display("testbench: done, errors");
    $finish;
  end

  // Both channels are sampled here so that inputs are noted before results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_item(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
    end
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    in_item_t it;
    it.in_byte = b;
    it.in_last = last;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Returns once every expected result is out and the pipeline has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_direction(d);
    dir_writes++;
  endtask

  // Mostly alphabet text, with padding, whitespace and stray bytes mixed in.
  task automatic send_text_message();
    int         len;
    bit         pad_end;
    logic [7:0] c;
    len     = $urandom_range(1, 12);
    pad_end = ($urandom_range(99) < 30);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 85) begin
        c = sb.sym_of(6'($urandom_range(63)));
      end else begin
        case ($urandom_range(5))
          0: c = CHAR_PAD;
          1: c = CHAR_SPACE;
          2: c = CHAR_LF;
          3: c = CHAR_CR;
          4: c = CHAR_TAB;
          default: c = 8'($urandom_range(255));
        endcase
      end
      send_item(c, (i == len - 1) && !pad_end);
      random_items++;
    end
    if (pad_end) begin
      send_item(CHAR_PAD, 1'b1);
      random_items++;
    end
  endtask

  task automatic send_byte_message();
    int         len;
    logic [7:0] b;
    len = $urandom_range(1, 9);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        b = $urandom_range(1) ? 8'hFF : 8'h00;
      end else begin
        b = 8'($urandom_range(255));
      end
      send_item(b, i == len - 1);
      random_items++;
    end
  endtask

  initial begin : stimulus
    int phase;
    sb           = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = DIR_DECODE;
    in_valid     = 1'b0;
    in_data      = '0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    random_items = 0;
    dir_writes   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Decode from reset: alphabet extremes with skipped bytes between them.
    send_item("+", 1'b0);
    send_item("/", 1'b0);
    send_item("A", 1'b0);
    send_item(8'h00, 1'b0);
    send_item("Z", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item("a", 1'b0);
    send_item(CHAR_LF, 1'b0);
    send_item("z", 1'b0);
    send_item("0", 1'b0);
    send_item(CHAR_PAD, 1'b0);
    send_item("9", 1'b1);
    // Leftover bits are dropped and a skipped last item gives a terminator.
    send_item("Q", 1'b0);
    send_item(CHAR_SPACE, 1'b1);
    send_item("T", 1'b0);
    send_item("Q", 1'b0);
    send_item(CHAR_PAD, 1'b0);
    send_item(CHAR_PAD, 1'b1);
    wait_idle();

    // Encode: one- and two-byte final groups, then a full group of '+' and '/'.
    write_direction(DIR_ENCODE);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h12, 1'b0);
    wait_idle();
    // Rewriting the same direction must drop the two bits still held.
    write_direction(DIR_ENCODE);
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b1);
    wait_idle();

    phase = 0;
    while (random_items < RANDOM_ITEMS || phase < MIN_PHASES) begin
      no_idle = (phase == 1);
      write_direction((phase % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
      // The receiver holds off while bytes keep coming, so the codec backs up.
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      for (int m = 0; m < 4; m++) begin
        if (sb.direction == DIR_ENCODE) begin
          send_byte_message();
        end else begin
          send_text_message();
        end
      end
      wait_idle();
      phase++;
    end
    no_idle = 1'b0;

    $display("summary: %0d input transactions, %0d results checked, %0d of them terminators",
             sb.inputs_seen, sb.results_seen, sb.terminators);
    $display("summary: %0d direction writes, %0d random phases, one long output hold-off",
             dir_writes, phase);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/b64c_pkg.sv
rtl/base64_stream_codec.sv
sim/testbench.sv
